[rtl/rgfs_pkg.sv]
// Package for the ranged stereo gain and fade block.
// Holds the widths, register codes, mode codes and word types that all files share.
// Depends on nothing.
package rgfs_pkg;

    // Field widths
    localparam int IDX_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int NORM_W   = 22;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;

    // Gain format: unsigned, six integer bits plus the fraction
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 6;
    localparam int CMP_W          = (NORM_W > GAIN_W) ? NORM_W : GAIN_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(32) << GAIN_FRAC_BITS;

    // Product and rounding widths
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int RND_W  = PROD_W - GAIN_FRAC_BITS + 1;

    localparam logic [GAIN_FRAC_BITS-1:0] RND_HALF = {1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};
    localparam logic [RND_W-1:0] SAT_POS_MAG = RND_W'((1 << (SAMPLE_W-1)) - 1);
    localparam logic [RND_W-1:0] SAT_NEG_MAG = RND_W'(1 << (SAMPLE_W-1));
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Processing modes
    typedef enum logic [1:0] {
        MODE_FLAT     = 2'd0,
        MODE_NORM     = 2'd1,
        MODE_FADE_IN  = 2'd2,
        MODE_FADE_OUT = 2'd3
    } mode_t;

    // Register indexes on the configuration port
    typedef enum logic [ADDR_W-3:0] {
        REG_MODE  = 3'd0,
        REG_START = 3'd1,
        REG_END   = 3'd2,
        REG_GAIN  = 3'd3,
        REG_FADE  = 3'd4
    } reg_idx_t;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        mode_t              mode;
        logic [IDX_W-1:0]   range_start;
        logic [IDX_W-1:0]   range_end;
        logic [NORM_W-1:0]  norm_gain;
        logic [IDX_W-1:0]   fade_length;
    } cfg_t;

    // Samples with the gain that applies to them
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [GAIN_W-1:0]          gain;
    } side_t;

    // Word travelling through the fade divider
    typedef struct packed {
        side_t                     side;
        logic                      ramp;
        logic [IDX_W-1:0]          rem;
        logic [GAIN_FRAC_BITS-1:0] quot;
    } div_word_t;

endpackage

[rtl/ranged_gain_fade_stereo_top.sv]
// Ranged stereo gain and fade stage: top level.
// Pipeline depth: GAIN_FRAC_BITS + 6 register stages, with the gain in Q6.16.
// Throughput: one word per cycle while the output is not stalled; the fade divider is
// pipelined one quotient bit per stage.
// A stalled output holds only the stages behind it that are full; empty stages still fill.
// Reset clears every valid bit and loads the registers with their reset values.
// Depends on rgfs_pkg, rgfs_cfg, rgfs_front, rgfs_div and rgfs_scale.
module ranged_gain_fade_stereo_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rgfs_pkg::ADDR_W-1:0]          paddr,
    input  logic [rgfs_pkg::DATA_W-1:0]          pwdata,
    output logic [rgfs_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rgfs_pkg::IDX_W-1:0]           frame_index,
    input  logic signed [rgfs_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [rgfs_pkg::SAMPLE_W-1:0] right_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rgfs_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [rgfs_pkg::SAMPLE_W-1:0] right_out
);
    import rgfs_pkg::*;

    cfg_t      cfg;
    logic      front_ready;
    logic      front_valid;
    div_word_t front_word;
    logic      div_ready;
    logic      div_valid;
    side_t     div_word;
    logic      scale_ready;

    assign in_stall = !front_ready;

    // Configuration registers
    rgfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Range check and gain selection
    rgfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (front_ready),
        .frame_index (frame_index),
        .left_in     (left_in),
        .right_in    (right_in),
        .out_valid   (front_valid),
        .out_word    (front_word),
        .out_ready   (div_ready)
    );

    // Fade factor division
    rgfs_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .fade_length (cfg.fade_length),
        .in_valid    (front_valid),
        .in_ready    (div_ready),
        .in_word     (front_word),
        .out_valid   (div_valid),
        .out_word    (div_word),
        .out_ready   (scale_ready)
    );

    // Multiply, round and saturate
    rgfs_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (scale_ready),
        .in_word   (div_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule

[rtl/rgfs_cfg.sv]
// Configuration register file on an APB-style port.
// Depends on rgfs_pkg for the register codes and the configuration type.
module rgfs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rgfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [rgfs_pkg::DATA_W-1:0]  pwdata,
    output logic [rgfs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output rgfs_pkg::cfg_t               cfg
);
    import rgfs_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_FLAT;
            cfg_reg.range_start <= '0;
            cfg_reg.range_end   <= '0;
            cfg_reg.norm_gain   <= NORM_W'(GAIN_ONE);
            cfg_reg.fade_length <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:  cfg_reg.mode        <= mode_t'(pwdata[1:0]);
                REG_START: cfg_reg.range_start <= pwdata[IDX_W-1:0];
                REG_END:   cfg_reg.range_end   <= pwdata[IDX_W-1:0];
                REG_GAIN:  cfg_reg.norm_gain   <= pwdata[NORM_W-1:0];
                REG_FADE:  cfg_reg.fade_length <= pwdata[IDX_W-1:0];
                default:   ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:  prdata = DATA_W'(cfg_reg.mode);
            REG_START: prdata = DATA_W'(cfg_reg.range_start);
            REG_END:   prdata = DATA_W'(cfg_reg.range_end);
            REG_GAIN:  prdata = DATA_W'(cfg_reg.norm_gain);
            REG_FADE:  prdata = DATA_W'(cfg_reg.fade_length);
            default:   prdata = '0;
        endcase
    end

endmodule

[rtl/rgfs_front.sv]
// Front end: range check, ramp position and gain selection over two stages.
// Depends on rgfs_pkg for the configuration and divider word types.
module rgfs_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rgfs_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rgfs_pkg::IDX_W-1:0]          frame_index,
    input  logic signed [rgfs_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [rgfs_pkg::SAMPLE_W-1:0] right_in,
    output logic                                out_valid,
    output rgfs_pkg::div_word_t                 out_word,
    input  logic                                out_ready
);
    import rgfs_pkg::*;

    logic                        s1_valid_reg;
    mode_t                       s1_mode_reg;
    mode_t                       s1_mode_next;
    logic [IDX_W-1:0]            s1_k_reg;
    logic [IDX_W-1:0]            s1_k_next;
    logic signed [SAMPLE_W-1:0]  s1_left_reg;
    logic signed [SAMPLE_W-1:0]  s1_right_reg;
    logic                        s2_valid_reg;
    div_word_t                   s2_word_reg;
    div_word_t                   s2_word_next;
    logic                        in_range;
    logic                        adv1;
    logic                        adv2;

    // A stage loads when it is empty or its content moves on
    assign adv2      = !s2_valid_reg || out_ready;
    assign adv1      = !s1_valid_reg || adv2;
    assign in_ready  = adv1;
    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

    // Stage one: range test and ramp position. Frames outside the range act as flat.
    always_comb
    begin
        in_range     = (frame_index >= cfg.range_start) && (frame_index < cfg.range_end);
        s1_mode_next = in_range ? cfg.mode : MODE_FLAT;
        // Fade-out counts back from the last frame: end - 1 - index
        if (cfg.mode == MODE_FADE_IN)
            s1_k_next = frame_index - cfg.range_start;
        else
            s1_k_next = cfg.range_end + ~frame_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_mode_reg  <= s1_mode_next;
            s1_k_reg     <= s1_k_next;
            s1_left_reg  <= left_in;
            s1_right_reg <= right_in;
        end
    end

    // Stage two: pick a fixed gain, or mark the word for the ramp division
    always_comb
    begin
        s2_word_next.side.left  = s1_left_reg;
        s2_word_next.side.right = s1_right_reg;
        s2_word_next.side.gain  = GAIN_ONE;
        s2_word_next.ramp       = 1'b0;
        s2_word_next.rem        = s1_k_reg;
        s2_word_next.quot       = '0;
        case (s1_mode_reg) inside
            MODE_NORM:
            begin
                if (CMP_W'(cfg.norm_gain) > CMP_W'(GAIN_MAX))
                    s2_word_next.side.gain = GAIN_MAX;
                else
                    s2_word_next.side.gain = GAIN_W'(cfg.norm_gain);
            end
            MODE_FADE_IN, MODE_FADE_OUT:
            begin
                // Beyond the ramp, or with no ramp at all, the gain stays at one
                s2_word_next.ramp = (s1_k_reg < cfg.fade_length);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
            s2_word_reg <= s2_word_next;
    end

endmodule

[rtl/rgfs_div.sv]
// Pipelined restoring divider for the fade factor, one quotient bit per stage.
// Depends on rgfs_pkg for the divider word and gain types.
module rgfs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rgfs_pkg::IDX_W-1:0] fade_length,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rgfs_pkg::div_word_t       in_word,
    output logic                      out_valid,
    output rgfs_pkg::side_t           out_word,
    input  logic                      out_ready
);
    import rgfs_pkg::*;

    localparam int NSTAGE = GAIN_FRAC_BITS;

    logic      valid_reg [NSTAGE];
    div_word_t word_reg  [NSTAGE];
    logic      stage_valid [NSTAGE];
    div_word_t stage_word  [NSTAGE];
    logic      adv [NSTAGE+1];

    assign adv[NSTAGE] = out_ready;
    assign in_ready    = adv[0];

    // Each stage doubles the partial remainder and takes off the fade length if it fits.
    // The remainder starts at k, which is below the fade length for ramp words.
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_stage
        logic [IDX_W:0] rem_dbl;
        logic [IDX_W:0] diff;
        div_word_t      word_next;

        if (i == 0)
        begin : g_first
            assign stage_valid[i] = in_valid;
            assign stage_word[i]  = in_word;
        end
        else
        begin : g_rest
            assign stage_valid[i] = valid_reg[i-1];
            assign stage_word[i]  = word_reg[i-1];
        end

        assign adv[i] = !valid_reg[i] || adv[i+1];

        always_comb
        begin
            rem_dbl   = {stage_word[i].rem, 1'b0};
            diff      = rem_dbl - {1'b0, fade_length};
            word_next = stage_word[i];
            if (!diff[IDX_W])
            begin
                word_next.rem  = diff[IDX_W-1:0];
                word_next.quot = {stage_word[i].quot[GAIN_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                word_next.rem  = rem_dbl[IDX_W-1:0];
                word_next.quot = {stage_word[i].quot[GAIN_FRAC_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (adv[i])
                valid_reg[i] <= stage_valid[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv[i] && stage_valid[i])
                word_reg[i] <= word_next;
        end
    end

    // Ramp words take the quotient as their gain
    always_comb
    begin
        out_word = word_reg[NSTAGE-1].side;
        if (word_reg[NSTAGE-1].ramp)
            out_word.gain = GAIN_W'(word_reg[NSTAGE-1].quot);
    end

    assign out_valid = valid_reg[NSTAGE-1];

endmodule

[rtl/rgfs_scale.sv]
// Scaling back end: multiply, magnitude, round half to even, saturate; four stages.
// Depends on rgfs_pkg for the widths, limits and the sample word type.
module rgfs_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  rgfs_pkg::side_t                      in_word,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rgfs_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [rgfs_pkg::SAMPLE_W-1:0] right_out
);
    import rgfs_pkg::*;

    localparam int NLANE = 2;

    logic                        m_valid_reg;
    logic signed [PROD_W-1:0]    m_prod_reg [NLANE];
    logic signed [PROD_W-1:0]    m_prod_next [NLANE];
    logic                        a_valid_reg;
    logic                        a_neg_reg [NLANE];
    logic [PROD_W-1:0]           a_mag_reg [NLANE];
    logic [PROD_W-1:0]           a_mag_next [NLANE];
    logic                        b_valid_reg;
    logic                        b_neg_reg [NLANE];
    logic [RND_W-1:0]            b_q_reg [NLANE];
    logic [RND_W-1:0]            b_q_next [NLANE];
    logic                        r_valid_reg;
    logic signed [SAMPLE_W-1:0]  r_sample_reg [NLANE];
    logic signed [SAMPLE_W-1:0]  r_sample_next [NLANE];
    logic signed [SAMPLE_W-1:0]  lane_in [NLANE];
    logic [GAIN_FRAC_BITS-1:0]   frac [NLANE];
    logic                        round_up [NLANE];
    logic                        adv_m;
    logic                        adv_a;
    logic                        adv_b;
    logic                        adv_r;

    assign adv_r     = !r_valid_reg || !out_stall;
    assign adv_b     = !b_valid_reg || adv_r;
    assign adv_a     = !a_valid_reg || adv_b;
    assign adv_m     = !m_valid_reg || adv_a;
    assign in_ready  = adv_m;
    assign out_valid = r_valid_reg;
    assign left_out  = r_sample_reg[0];
    assign right_out = r_sample_reg[1];

    assign lane_in[0] = in_word.left;
    assign lane_in[1] = in_word.right;

    // Per-lane arithmetic; the lanes are independent
    always_comb
    begin
        for (int n = 0; n < NLANE; n++)
        begin
            // Signed sample times unsigned gain
            m_prod_next[n] = PROD_W'($signed(lane_in[n])) * $signed(PROD_W'(in_word.gain));

            // Magnitude of the product
            if (m_prod_reg[n][PROD_W-1])
                a_mag_next[n] = PROD_W'(-m_prod_reg[n]);
            else
                a_mag_next[n] = PROD_W'(m_prod_reg[n]);

            // Round to nearest, ties to even
            frac[n]     = a_mag_reg[n][GAIN_FRAC_BITS-1:0];
            round_up[n] = (frac[n] > RND_HALF) ||
                          ((frac[n] == RND_HALF) && a_mag_reg[n][GAIN_FRAC_BITS]);
            b_q_next[n] = RND_W'(a_mag_reg[n][PROD_W-1:GAIN_FRAC_BITS]) + RND_W'(round_up[n]);

            // Saturate to the sample range and restore the sign
            if (b_neg_reg[n])
            begin
                if (b_q_reg[n] > SAT_NEG_MAG)
                    r_sample_next[n] = SAMPLE_MIN;
                else
                    r_sample_next[n] = -$signed(b_q_reg[n][SAMPLE_W-1:0]);
            end
            else
            begin
                if (b_q_reg[n] > SAT_POS_MAG)
                    r_sample_next[n] = SAMPLE_MAX;
                else
                    r_sample_next[n] = $signed(b_q_reg[n][SAMPLE_W-1:0]);
            end
        end
    end

    // Valid bits of the four stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_m)
                m_valid_reg <= in_valid;
            if (adv_a)
                a_valid_reg <= m_valid_reg;
            if (adv_b)
                b_valid_reg <= a_valid_reg;
            if (adv_r)
                r_valid_reg <= b_valid_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < NLANE; n++)
        begin
            if (adv_m && in_valid)
                m_prod_reg[n] <= m_prod_next[n];
            if (adv_a && m_valid_reg)
            begin
                a_neg_reg[n] <= m_prod_reg[n][PROD_W-1];
                a_mag_reg[n] <= a_mag_next[n];
            end
            if (adv_b && a_valid_reg)
            begin
                b_neg_reg[n] <= a_neg_reg[n];
                b_q_reg[n]   <= b_q_next[n];
            end
            if (adv_r && b_valid_reg)
                r_sample_reg[n] <= r_sample_next[n];
        end
    end

endmodule

[sim/tb.sv]
// Testbench for the ranged stereo gain and fade stage: drives frames and register writes,
// predicts every output word and checks it field by field against the block.
// Depends on rgfs_pkg and ranged_gain_fade_stereo_top.
module tb;

    import rgfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 12;
    localparam int FRAMES_PER_SET = 125;

    // Expected output words, worked out from the register copy at the time of acceptance.
    class gain_scoreboard;

        typedef struct {
            logic signed [SAMPLE_W-1:0] left;
            logic signed [SAMPLE_W-1:0] right;
        } stereo_t;

        mode_t             mode;
        logic [IDX_W-1:0]  range_start;
        logic [IDX_W-1:0]  range_end;
        logic [NORM_W-1:0] norm_gain;
        logic [IDX_W-1:0]  fade_length;
        stereo_t           expected_q[$];
        int                errors;
        int                checked;

        function new();
            mode        = MODE_FLAT;
            range_start = '0;
            range_end   = '0;
            norm_gain   = NORM_W'(GAIN_ONE);
            fade_length = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MODE:  mode        = mode_t'(value[1:0]);
                REG_START: range_start = value;
                REG_END:   range_end   = value;
                REG_GAIN:  norm_gain   = value[NORM_W-1:0];
                REG_FADE:  fade_length = value;
                default:   ;
            endcase
        endfunction

        // Gain that applies to a frame at the given index.
        function logic [GAIN_W-1:0] gain_for(logic [IDX_W-1:0] idx);
            logic [IDX_W-1:0]  k;
            longint unsigned   num;
            k = '0;
            if (idx < range_start || idx >= range_end)
                return GAIN_ONE;
            case (mode)
                MODE_NORM:
                    return (norm_gain > GAIN_MAX) ? GAIN_MAX : GAIN_W'(norm_gain);
                MODE_FADE_IN:  k = idx - range_start;
                MODE_FADE_OUT: k = range_end - 1 - idx;
                default:
                    return GAIN_ONE;
            endcase
            if (fade_length != 0 && k < fade_length)
            begin
                num = longint'(k) << GAIN_FRAC_BITS;
                return GAIN_W'(num / longint'(fade_length));
            end
            return GAIN_ONE;
        endfunction

        // Product rounded to nearest, ties to even, then saturated to a sample.
        function logic signed [SAMPLE_W-1:0] scale(logic signed [SAMPLE_W-1:0] s,
                                                   logic [GAIN_W-1:0] g);
            longint          prod;
            longint unsigned mag;
            longint unsigned q;
            longint unsigned rem;
            longint unsigned half;
            prod = longint'(s) * longint'(g);
            mag  = (prod < 0) ? longint'(-prod) : longint'(prod);
            q    = mag >> GAIN_FRAC_BITS;
            rem  = mag & ((longint'(1) << GAIN_FRAC_BITS) - 1);
            half = longint'(1) << (GAIN_FRAC_BITS - 1);
            if (rem > half || (rem == half && q[0]))
                q++;
            if (prod < 0)
                return (q > 32768) ? SAMPLE_MIN : SAMPLE_W'(-longint'(q));
            return (q > 32767) ? SAMPLE_MAX : SAMPLE_W'(q);
        endfunction

        function void note_frame(logic [IDX_W-1:0] idx, logic signed [SAMPLE_W-1:0] left,
                                 logic signed [SAMPLE_W-1:0] right);
            stereo_t          f;
            logic [GAIN_W-1:0] g;
            g       = gain_for(idx);
            f.left  = scale(left, g);
            f.right = scale(right, g);
            expected_q.push_back(f);
        endfunction

        function void check_frame(logic signed [SAMPLE_W-1:0] left,
                                  logic signed [SAMPLE_W-1:0] right);
            stereo_t f;
            if (expected_q.size() == 0)
            begin
                $error("output word with none expected: left_out %0d right_out %0d",
                       left, right);
                errors++;
                return;
            end
            f = expected_q.pop_front();
            checked++;
            if (left !== f.left)
            begin
                $error("left_out mismatch: expected %0d, got %0d", f.left, left);
                errors++;
            end
            if (right !== f.right)
            begin
                $error("right_out mismatch: expected %0d, got %0d", f.right, right);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [ADDR_W-1:0]          paddr       = '0;
    logic [DATA_W-1:0]          pwdata      = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic [IDX_W-1:0]           frame_index = '0;
    logic signed [SAMPLE_W-1:0] left_in     = '0;
    logic signed [SAMPLE_W-1:0] right_in    = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    int             send_idle_pct  = 18;
    int             recv_stall_pct = 75;
    int             settings_made  = 0;
    gain_scoreboard sb             = new();

    ranged_gain_fade_stereo_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random according to the current idling regime.
    always @(posedge clk)
    begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Note every accepted input word and check every accepted output word.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_frame(frame_index, left_in, right_in);
        if (rst_n && out_valid && !out_stall)
            sb.check_frame(left_out, right_out);
    end

    // Ends the run when nothing at all has moved for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offers one frame, with random idle cycles first, and returns at the accepting edge.
    task automatic send_frame(input logic [IDX_W-1:0] idx,
                              input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        frame_index <= idx;
        left_in     <= left;
        right_in    <= right;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops offering frames and waits until every expected word has come out.
    // The extra edge lets the monitor note a word accepted at the edge this task starts on.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One write: a setup cycle, an access cycle, then an idle cycle on the port.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input mode_t mode, input logic [IDX_W-1:0] first,
                                 input logic [IDX_W-1:0] last, input logic [NORM_W-1:0] gain,
                                 input logic [IDX_W-1:0] fade);
        drain_frames();
        write_reg(REG_MODE, DATA_W'(mode));
        write_reg(REG_START, first);
        write_reg(REG_END, last);
        write_reg(REG_GAIN, DATA_W'(gain));
        write_reg(REG_FADE, fade);
        settings_made++;
    endtask

    // Mostly uniform samples, with the extremes and values near zero now and then.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(19))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(2)) - 1);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // A random register setting with a stream of mostly consecutive frames around its range.
    task automatic random_phase();
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
        logic [IDX_W-1:0]  fade;
        logic [NORM_W-1:0] gain;
        logic [IDX_W-1:0]  cur;
        int                pick;
        case ($urandom_range(3))
            0:       first = '0;
            1:       first = $urandom_range(5000);
            2:       first = 32'hFFFF_FFFF - $urandom_range(300);
            default: first = $urandom();
        endcase
        case ($urandom_range(4))
            0:       last = first + $urandom_range(400);
            1:       last = first + $urandom_range(40);
            2:       last = 32'hFFFF_FFFF;
            3:       last = first - $urandom_range(50);
            default: last = $urandom();
        endcase
        case ($urandom_range(5))
            0:       fade = '0;
            1:       fade = 1;
            2:       fade = $urandom_range(2, 60);
            3:       fade = $urandom_range(61, 1000);
            4:       fade = 32'hFFFF_FFFF;
            default: fade = $urandom();
        endcase
        case ($urandom_range(5))
            0:       gain = '0;
            1:       gain = GAIN_MAX;
            2:       gain = '1;
            3:       gain = NORM_W'($urandom_range(GAIN_ONE / 2, 4 * GAIN_ONE));
            4:       gain = NORM_W'($urandom_range(GAIN_ONE));
            default: gain = NORM_W'($urandom());
        endcase
        load_settings(mode_t'($urandom_range(3)), first, last, gain, fade);
        cur = first - $urandom_range(40);
        for (int n = 0; n < FRAMES_PER_SET; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                cur = cur + 1;
            else if (pick < 85)
                cur = last - 3 + $urandom_range(6);
            else if (pick < 93)
                cur = first - 3 + $urandom_range(6);
            else
                cur = $urandom();
            send_frame(cur, rand_sample(), rand_sample());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gain above the ceiling is clipped to 32.0; the last index lies past the range.
        load_settings(MODE_NORM, 32'h0, 32'hFFFF_FFFF, '1, 32'h0);
        send_frame(32'h0, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'hFFFF_FFFE, 16'sd1, -16'sd1);
        send_frame(32'hFFFF_FFFF, 16'sd1000, -16'sd1000);

        // A gain of one half exercises ties to even and the extreme samples.
        load_settings(MODE_NORM, 32'h0, 32'hFFFF_FFFF, NORM_W'(GAIN_ONE / 2), 32'h0);
        send_frame(32'd1, 16'sd3, -16'sd3);
        send_frame(32'd2, 16'sd5, -16'sd5);
        send_frame(32'd3, SAMPLE_MAX, SAMPLE_MIN);

        // Zero gain silences the frame.
        load_settings(MODE_NORM, 32'h0, 32'hFFFF_FFFF, '0, 32'h0);
        send_frame(32'd7, 16'sd12345, SAMPLE_MIN);

        // Fade in across the ramp, its end and both range edges.
        load_settings(MODE_FADE_IN, 32'd100, 32'd200, NORM_W'(GAIN_ONE), 32'd10);
        send_frame(32'd99, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd100, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd101, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd105, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd109, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd110, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd199, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd200, SAMPLE_MAX, SAMPLE_MIN);

        // Fade out counts back from the end of the range.
        load_settings(MODE_FADE_OUT, 32'd100, 32'd200, NORM_W'(GAIN_ONE), 32'd3);
        send_frame(32'd199, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd198, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd197, -16'sd20001, 16'sd20001);
        send_frame(32'd196, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(32'd100, 16'sd1, -16'sd1);

        // An inverted range processes nothing; a zero fade length gives unity.
        load_settings(MODE_FLAT, 32'd200, 32'd100, GAIN_MAX, 32'h0);
        send_frame(32'd150, -16'sd1, 16'sd1);
        load_settings(MODE_FADE_IN, 32'h0, 32'hFFFF_FFFF, GAIN_MAX, 32'h0);
        send_frame(32'd12, SAMPLE_MAX, SAMPLE_MIN);

        // Random settings under three idling regimes in turn.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES / 3)
            begin
                send_idle_pct  = 75;
                recv_stall_pct = 18;
            end
            else if (p == 2 * PHASES / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            random_phase();
        end

        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d output words over %0d register settings,", sb.checked,
                 settings_made);
        $display("covering all four modes, range edges, fade ramps and gain saturation.");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/rgfs_pkg.sv
rtl/rgfs_cfg.sv
rtl/rgfs_front.sv
rtl/rgfs_div.sv
rtl/rgfs_scale.sv
rtl/ranged_gain_fade_stereo_top.sv
sim/tb.sv
